FILE: src/dspc_pkg.sv
// Shared types and constants for the dual stepper pulse controller.
// No dependencies; imported by every module of the block.
package dspc_pkg;

   localparam int MOTOR_COUNT = 2;
   localparam int MOTOR_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [15:0] RESET_STEP_INTERVAL = 16'd1200;
   localparam logic [15:0] RESET_STEPS_PER_REV = 16'd200;
   localparam logic [15:0] DEG_PER_REV = 16'd360;
   localparam logic [31:0] HALF_DEG = 32'd180;

   // x / 360 = (x >> 3) / 45; the /45 is a multiply by ceil(2^35 / 45), exact below 2^29
   localparam int          ANGLE_PRE_SHIFT   = 3;
   localparam logic [29:0] ANGLE_RECIP       = 30'd763549742;
   localparam int          ANGLE_RECIP_SHIFT = 35;

   localparam int DIV_CNT_W = 6;
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS_MOD = 6'd16;
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS_DEG = 6'd25;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_TIMED = 2'd1,
      KIND_ANGLE = 2'd2,
      KIND_QUERY = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_BAD_MOTOR    = 3'd1,
      ST_BUSY         = 3'd2,
      ST_BAD_DURATION = 3'd3,
      ST_BAD_ANGLE    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CSR_STEP_INTERVAL = 2'd0,
      CSR_STEPS_PER_REV = 2'd1
   } csr_index_type;

   // classified command as it sits in the queue
   typedef struct packed {
      kind_type            kind;
      logic                idx_ok;
      logic [MOTOR_W-1:0]  motor;
      logic                arg_ok;
      logic [30:0]         duration;
      logic [14:0]         angle;
      logic [31:0]         now_ms;
      logic [31:0]         now_us;
   } cmd_type;

   typedef struct packed {
      logic                  start;
      logic [31:0]           dividend;
      logic [15:0]           divisor;
      logic [DIV_CNT_W-1:0]  steps;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
      logic [15:0] remainder;
   } div_rsp_type;

endpackage

FILE: src/dspc_front.sv
// Front end: accepts request beats, checks index and argument, pushes to the queue.
// Depends on dspc_pkg.
module dspc_front
   import dspc_pkg::*;
(
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic [1:0]         req_motor_index,
   input  logic [30:0]        req_duration_ms,
   input  logic signed [15:0] req_angle_deg,
   input  logic [31:0]        req_now_ms,
   input  logic [31:0]        req_now_us,
   input  logic               q_full,
   output logic               q_push,
   output cmd_type            q_wdata
);

   kind_type   kind;
   logic       idx_ok;
   logic [1:0] idx_m1;
   logic       angle_pos;

   assign kind      = kind_type'(req_kind);
   assign idx_ok    = (req_motor_index != 2'd0) && (req_motor_index <= 2'(MOTOR_COUNT));
   assign idx_m1    = req_motor_index - 2'd1;
   assign angle_pos = !req_angle_deg[15] && (req_angle_deg != 16'sd0);

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_wdata.kind     = kind;
      q_wdata.idx_ok   = idx_ok;
      q_wdata.motor    = idx_ok ? idx_m1[MOTOR_W-1:0] : '0;
      q_wdata.duration = req_duration_ms;
      q_wdata.angle    = req_angle_deg[14:0];
      q_wdata.now_ms   = req_now_ms;
      q_wdata.now_us   = req_now_us;
      case (kind)
         KIND_TIMED: q_wdata.arg_ok = (req_duration_ms != 31'd0);
         KIND_ANGLE: q_wdata.arg_ok = angle_pos;
         default:    q_wdata.arg_ok = 1'b1;
      endcase
   end

endmodule

FILE: src/dspc_fifo.sv
// Short command queue between front and back end, first-word fall-through.
// Depends on dspc_pkg.
module dspc_fifo
   import dspc_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type wdata,
   input  logic    pop,
   output cmd_type rdata,
   output logic    full,
   output logic    empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign rdata = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

FILE: src/dspc_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, 32-bit dividend, 16-bit divisor.
// Depends on dspc_pkg. Dividend comes left-aligned; steps gives its significant bits.
module dspc_div
   import dspc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [15:0]          rem_ff, rem_in;
   logic [31:0]          quo_ff, quo_in;
   logic [15:0]          dvsr_ff, dvsr_in;
   logic [16:0]          shifted;
   logic                 fits;

   assign shifted = {rem_ff, quo_ff[31]};
   assign fits    = (shifted >= {1'b0, dvsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvsr_in = dvsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = div_req.steps;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvsr_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? 16'(shifted - {1'b0, dvsr_ff}) : shifted[15:0];
         quo_in = {quo_ff[30:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvsr_ff <= dvsr_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

FILE: src/dspc_back.sv
// Back end: sequencer that runs one command on the motor state and builds the response.
// Depends on dspc_pkg; drives the shared serial divider dspc_div.
module dspc_back
   import dspc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [15:0]            step_interval,
   input  logic [15:0]            steps_per_rev,
   input  logic                   q_empty,
   input  cmd_type                q_rdata,
   output logic                   q_pop,
   output div_req_type            div_req,
   input  div_rsp_type            div_rsp,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [2:0]             rsp_status,
   output logic [MOTOR_COUNT-1:0] rsp_step_mask,
   output logic [MOTOR_COUNT-1:0] rsp_enable_mask,
   output logic                   rsp_running,
   output logic [8:0]             rsp_position_deg
);

   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_AMUL   = 11'b00000000010,
      S_ASHIFT = 11'b00000000100,
      S_ARECIP = 11'b00000001000,
      S_APPLY  = 11'b00000010000,
      S_POS    = 11'b00000100000,
      S_MWAIT  = 11'b00001000000,
      S_DMUL   = 11'b00010000000,
      S_DGO    = 11'b00100000000,
      S_DWAIT  = 11'b01000000000,
      S_OUT    = 11'b10000000000
   } state_type;

   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [30:0]      prod_ff, prod_in;
   logic [23:0]      steps_ff, steps_in;
   status_type       status_ff, status_in;
   logic [MOTOR_COUNT-1:0] smask_ff, smask_in;
   logic [15:0]      rem_ff, rem_in;
   logic [8:0]       deg_ff, deg_in;

   // per-motor run state
   logic             active_ff [MOTOR_COUNT];
   logic             active_in [MOTOR_COUNT];
   logic             timed_ff [MOTOR_COUNT];
   logic             timed_in [MOTOR_COUNT];
   logic [31:0]      end_ff [MOTOR_COUNT];
   logic [31:0]      end_in [MOTOR_COUNT];
   logic [31:0]      last_ff [MOTOR_COUNT];
   logic [31:0]      last_in [MOTOR_COUNT];
   logic [23:0]      left_ff [MOTOR_COUNT];
   logic [23:0]      left_in [MOTOR_COUNT];
   logic [15:0]      pos_ff [MOTOR_COUNT];
   logic [15:0]      pos_in [MOTOR_COUNT];

   logic [31:0]      ms_gap [MOTOR_COUNT];
   logic [31:0]      us_gap [MOTOR_COUNT];
   logic [23:0]      left_dec [MOTOR_COUNT];
   logic [15:0]      pos_inc [MOTOR_COUNT];
   logic [15:0]      pos_adv [MOTOR_COUNT];
   logic [MOTOR_COUNT-1:0] active_vec;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_status_ff, rsp_status_in;
   logic [MOTOR_COUNT-1:0] rsp_step_ff, rsp_step_in;
   logic [MOTOR_COUNT-1:0] rsp_enable_ff, rsp_enable_in;
   logic             rsp_running_ff, rsp_running_in;
   logic [8:0]       rsp_deg_ff, rsp_deg_in;

   logic [15:0]      mul_a;
   logic [14:0]      mul_b;
   logic [30:0]      mul_out;
   logic [58:0]      recip_prod;
   logic [15:0]      pos_sel;
   logic             need_mod;
   logic             out_load;

   // shared multiplier: angle * steps_per_rev, then remainder * 360
   assign mul_a   = (state_ff == S_AMUL) ? steps_per_rev : rem_ff;
   assign mul_b   = (state_ff == S_AMUL) ? cmd_ff.angle : DEG_PER_REV[14:0];
   assign mul_out = 31'(mul_a) * 31'(mul_b);

   // rounded steps: ((spr * angle + 180) >> 3) divided by 45 through its reciprocal
   assign recip_prod = 59'(prod_ff[27:0]) * 59'(ANGLE_RECIP);

   assign pos_sel  = pos_ff[cmd_ff.motor];
   assign need_mod = (pos_sel >= steps_per_rev);
   assign q_pop    = (state_ff == S_IDLE) && !q_empty;
   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      for (int k = 0; k < MOTOR_COUNT; k++) begin
         ms_gap[k]     = cmd_ff.now_ms - end_ff[k];
         us_gap[k]     = cmd_ff.now_us - last_ff[k];
         left_dec[k]   = left_ff[k] - 24'd1;
         pos_inc[k]    = pos_ff[k] + 16'd1;
         pos_adv[k]    = ((steps_per_rev != 16'd0) && (pos_inc[k] >= steps_per_rev)) ?
                         16'd0 : pos_inc[k];
         active_vec[k] = active_ff[k];
      end
   end

   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = steps_per_rev;
      div_req.steps    = DIV_STEPS_MOD;
      unique case (state_ff)
         S_POS: begin
            div_req.start    = cmd_ff.idx_ok && (steps_per_rev != 16'd0) && need_mod;
            div_req.dividend = {pos_sel, 16'd0};
            div_req.divisor  = steps_per_rev;
            div_req.steps    = DIV_STEPS_MOD;
         end
         S_DGO: begin
            div_req.start    = 1'b1;
            div_req.dividend = {prod_ff[24:0], 7'd0};
            div_req.divisor  = steps_per_rev;
            div_req.steps    = DIV_STEPS_DEG;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      prod_in   = prod_ff;
      steps_in  = steps_ff;
      status_in = status_ff;
      smask_in  = smask_ff;
      rem_in    = rem_ff;
      deg_in    = deg_ff;
      for (int k = 0; k < MOTOR_COUNT; k++) begin
         active_in[k] = active_ff[k];
         timed_in[k]  = timed_ff[k];
         end_in[k]    = end_ff[k];
         last_in[k]   = last_ff[k];
         left_in[k]   = left_ff[k];
         pos_in[k]    = pos_ff[k];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               cmd_in   = q_rdata;
               state_in = (q_rdata.kind == KIND_ANGLE && q_rdata.idx_ok && q_rdata.arg_ok) ?
                          S_AMUL : S_APPLY;
            end
         end
         S_AMUL: begin
            prod_in  = mul_out;
            state_in = S_ASHIFT;
         end
         S_ASHIFT: begin
            // sum stays below 2^31, shifted value below 2^28
            prod_in  = 31'(({1'b0, prod_ff} + HALF_DEG) >> ANGLE_PRE_SHIFT);
            state_in = S_ARECIP;
         end
         S_ARECIP: begin
            steps_in = recip_prod[ANGLE_RECIP_SHIFT +: 24];
            state_in = S_APPLY;
         end
         S_APPLY: begin
            status_in = ST_OK;
            smask_in  = '0;
            if (cmd_ff.kind == KIND_TICK) begin
               for (int k = 0; k < MOTOR_COUNT; k++) begin
                  if (active_ff[k]) begin
                     if (timed_ff[k] ? !ms_gap[k][31] : (left_ff[k] == 24'd0)) begin
                        // run finished: stop it
                        active_in[k] = 1'b0;
                        timed_in[k]  = 1'b0;
                        left_in[k]   = '0;
                     end else if (us_gap[k] >= {16'd0, step_interval}) begin
                        last_in[k]  = cmd_ff.now_us;
                        pos_in[k]   = pos_adv[k];
                        smask_in[k] = 1'b1;
                        if (!timed_ff[k]) begin
                           left_in[k] = left_dec[k];
                           if (left_dec[k] == 24'd0) begin
                              active_in[k] = 1'b0;
                              timed_in[k]  = 1'b0;
                           end
                        end
                     end
                  end
               end
            end else if (!cmd_ff.idx_ok) begin
               status_in = ST_BAD_MOTOR;
            end else if (cmd_ff.kind == KIND_QUERY) begin
               status_in = ST_OK;
            end else if (active_ff[cmd_ff.motor]) begin
               status_in = ST_BUSY;
            end else if (cmd_ff.kind == KIND_TIMED) begin
               if (!cmd_ff.arg_ok) begin
                  status_in = ST_BAD_DURATION;
               end else begin
                  active_in[cmd_ff.motor] = 1'b1;
                  timed_in[cmd_ff.motor]  = 1'b1;
                  end_in[cmd_ff.motor]    = cmd_ff.now_ms + {1'b0, cmd_ff.duration};
                  last_in[cmd_ff.motor]   = '0;
                  left_in[cmd_ff.motor]   = '0;
               end
            end else begin
               if (!cmd_ff.arg_ok || steps_ff == 24'd0) begin
                  status_in = ST_BAD_ANGLE;
               end else begin
                  active_in[cmd_ff.motor] = 1'b1;
                  timed_in[cmd_ff.motor]  = 1'b0;
                  end_in[cmd_ff.motor]    = '0;
                  last_in[cmd_ff.motor]   = '0;
                  left_in[cmd_ff.motor]   = steps_ff;
               end
            end
            state_in = S_POS;
         end
         S_POS: begin
            if (!cmd_ff.idx_ok || steps_per_rev == 16'd0) begin
               deg_in   = '0;
               state_in = S_OUT;
            end else if (need_mod) begin
               state_in = S_MWAIT;
            end else begin
               rem_in   = pos_sel;
               state_in = S_DMUL;
            end
         end
         S_MWAIT: begin
            if (div_rsp.done) begin
               rem_in   = div_rsp.remainder;
               state_in = S_DMUL;
            end
         end
         S_DMUL: begin
            prod_in  = mul_out;
            state_in = S_DGO;
         end
         S_DGO: begin
            state_in = S_DWAIT;
         end
         S_DWAIT: begin
            if (div_rsp.done) begin
               deg_in   = div_rsp.quotient[8:0];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in   = out_load || (rsp_valid_ff && rsp_stall);
      rsp_status_in  = rsp_status_ff;
      rsp_step_in    = rsp_step_ff;
      rsp_enable_in  = rsp_enable_ff;
      rsp_running_in = rsp_running_ff;
      rsp_deg_in     = rsp_deg_ff;
      if (out_load) begin
         rsp_status_in  = status_ff;
         rsp_step_in    = smask_ff;
         rsp_enable_in  = active_vec;
         rsp_running_in = cmd_ff.idx_ok && active_ff[cmd_ff.motor];
         rsp_deg_in     = deg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < MOTOR_COUNT; k++) begin
            active_ff[k] <= 1'b0;
            timed_ff[k]  <= 1'b0;
            end_ff[k]    <= '0;
            last_ff[k]   <= '0;
            left_ff[k]   <= '0;
            pos_ff[k]    <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < MOTOR_COUNT; k++) begin
            active_ff[k] <= active_in[k];
            timed_ff[k]  <= timed_in[k];
            end_ff[k]    <= end_in[k];
            last_ff[k]   <= last_in[k];
            left_ff[k]   <= left_in[k];
            pos_ff[k]    <= pos_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      prod_ff        <= prod_in;
      steps_ff       <= steps_in;
      status_ff      <= status_in;
      smask_ff       <= smask_in;
      rem_ff         <= rem_in;
      deg_ff         <= deg_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_step_ff    <= rsp_step_in;
      rsp_enable_ff  <= rsp_enable_in;
      rsp_running_ff <= rsp_running_in;
      rsp_deg_ff     <= rsp_deg_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_step_mask    = rsp_step_ff;
   assign rsp_enable_mask  = rsp_enable_ff;
   assign rsp_running      = rsp_running_ff;
   assign rsp_position_deg = rsp_deg_ff;

endmodule

FILE: src/dual_stepper_pulse_controller_core.sv
// Top level of the dual stepper pulse controller: config registers, front, queue, back, divider.
// Depends on dspc_pkg, dspc_front, dspc_fifo, dspc_div, dspc_back.
//
//   channel  handshake             beat contents
//   req      req_valid/req_stall   kind, motor_index, duration_ms, angle_deg, now_ms, now_us
//   rsp      rsp_valid/rsp_stall   status, step_mask, enable_mask, running, position_deg
//   csr      csr_valid/csr_ready   csr_index, csr_wdata (0 step interval, 1 steps per rev)
//
// Sequence: a beat runs one at a time through the back-end sequencer; with a valid index
//   and nonzero steps_per_rev it ends with the position divide (25 steps of the serial
//   divider). An angle start first forms the rounded steps (multiply, shift,
//   reciprocal multiply); a position at or above steps_per_rev adds the modulo
//   divide. Invalid index or zero steps_per_rev skips the divides.
// Reset: synchronous; all motor state and both registers load at once.
// Stalls: the queue holds QUEUE_DEPTH request beats while the back end works, the response
//   register one; rsp_stall halts the back end, and req_stall rises once the queue is full.
module dual_stepper_pulse_controller_core
   import dspc_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_kind,
   input  logic [1:0]             req_motor_index,
   input  logic [30:0]            req_duration_ms,
   input  logic signed [15:0]     req_angle_deg,
   input  logic [31:0]            req_now_ms,
   input  logic [31:0]            req_now_us,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [2:0]             rsp_status,
   output logic [MOTOR_COUNT-1:0] rsp_step_mask,
   output logic [MOTOR_COUNT-1:0] rsp_enable_mask,
   output logic                   rsp_running,
   output logic [8:0]             rsp_position_deg,
   // register write port
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_wdata
);

   logic [15:0]  step_interval_ff, step_interval_in;
   logic [15:0]  steps_per_rev_ff, steps_per_rev_in;

   logic         q_push;
   logic         q_pop;
   logic         q_full;
   logic         q_empty;
   cmd_type      q_wdata;
   cmd_type      q_rdata;
   div_req_type  div_req;
   div_rsp_type  div_rsp;

   // Writes must come only while the block is idle (unenforced); the port is always ready.
   assign csr_ready = 1'b1;

   always_comb begin
      step_interval_in = step_interval_ff;
      steps_per_rev_in = steps_per_rev_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_STEP_INTERVAL: step_interval_in = csr_wdata;
            CSR_STEPS_PER_REV: steps_per_rev_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_interval_ff <= RESET_STEP_INTERVAL;
         steps_per_rev_ff <= RESET_STEPS_PER_REV;
      end else begin
         step_interval_ff <= step_interval_in;
         steps_per_rev_ff <= steps_per_rev_in;
      end
   end

   // front: take and classify request beats
   dspc_front u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_motor_index (req_motor_index),
      .req_duration_ms (req_duration_ms),
      .req_angle_deg   (req_angle_deg),
      .req_now_ms      (req_now_ms),
      .req_now_us      (req_now_us),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_wdata         (q_wdata)
   );

   // command queue decouples front from back
   dspc_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .full  (q_full),
      .empty (q_empty)
   );

   // serial divider shared by modulo and degree conversion
   dspc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // back: motor state, step timing, response register
   dspc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .step_interval    (step_interval_ff),
      .steps_per_rev    (steps_per_rev_ff),
      .q_empty          (q_empty),
      .q_rdata          (q_rdata),
      .q_pop            (q_pop),
      .div_req          (div_req),
      .div_rsp          (div_rsp),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_step_mask    (rsp_step_mask),
      .rsp_enable_mask  (rsp_enable_mask),
      .rsp_running      (rsp_running),
      .rsp_position_deg (rsp_position_deg)
   );

endmodule

FILE: tb/sv/dual_stepper_pulse_controller_core_tb.sv
// Self-checking bench for dual_stepper_pulse_controller_core: directed table, then random phases.
// Needs dspc_pkg and the core RTL; predicts every reply beat in-line and compares field by field.
module dual_stepper_pulse_controller_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dspc_pkg::*;

   // one request beat, one reply beat, one row of the directed table
   typedef struct packed {
      kind_type           kind;
      logic [1:0]         idx;
      logic [30:0]        dur;
      logic signed [15:0] angle;
      logic [31:0]        now_ms;
      logic [31:0]        now_us;
   } motor_cmd_type;

   typedef struct packed {
      status_type  status;
      logic [1:0]  step_mask;
      logic [1:0]  enable_mask;
      logic        running;
      logic [8:0]  position_deg;
   } motor_rsp_type;

   typedef struct packed {
      motor_cmd_type cmd;
      logic          fixed;   // 1: reply typed in below, 0: reply from the predictor
      motor_rsp_type want;
   } dir_row_type;

   localparam int NUM_ROWS   = 23;
   localparam int NUM_PHASES = 8;
   localparam int PHASE_BEATS = 180;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [1:0]             req_kind;
   logic [1:0]             req_motor_index;
   logic [30:0]            req_duration_ms;
   logic signed [15:0]     req_angle_deg;
   logic [31:0]            req_now_ms;
   logic [31:0]            req_now_us;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [2:0]             rsp_status;
   logic [MOTOR_COUNT-1:0] rsp_step_mask;
   logic [MOTOR_COUNT-1:0] rsp_enable_mask;
   logic                   rsp_running;
   logic [8:0]             rsp_position_deg;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [1:0]             csr_index;
   logic [15:0]            csr_wdata;

   dual_stepper_pulse_controller_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_motor_index  (req_motor_index),
      .req_duration_ms  (req_duration_ms),
      .req_angle_deg    (req_angle_deg),
      .req_now_ms       (req_now_ms),
      .req_now_us       (req_now_us),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_step_mask    (rsp_step_mask),
      .rsp_enable_mask  (rsp_enable_mask),
      .rsp_running      (rsp_running),
      .rsp_position_deg (rsp_position_deg),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // ---------------------------------------------------------------------------------------
   // Motor state mirror: per-motor run flags, timers, step budget and position in the rev.
   // ---------------------------------------------------------------------------------------
   logic        run_on        [2];
   logic        timed_run     [2];
   logic [31:0] stop_ms       [2];
   logic [31:0] last_pulse_us [2];
   logic [23:0] steps_togo    [2];
   logic [15:0] rev_pos       [2];
   logic [15:0] cfg_interval;
   logic [15:0] cfg_spr;

   motor_rsp_type replies_due [$];   // replies owed by the block, oldest first
   int         fail_count;
   int         tx_idle_pct;       // chance that the sender pauses before a beat
   int         rx_stall_pct;      // per-cycle chance that the receiver stalls
   int         rx_hold;           // long receiver hold-off, counted down by the receiver
   logic [31:0] t_ms;             // running time base for well-formed traffic
   logic [31:0] t_us;

   function automatic void halt_motor(input int k);
      run_on[k]     = 1'b0;
      timed_run[k]  = 1'b0;
      steps_togo[k] = '0;
   endfunction

   // Applies one command to the mirror and returns the reply beat it causes.
   function automatic motor_rsp_type apply_command(input motor_cmd_type c);
      motor_rsp_type r;
      logic        sel_ok;
      int          m;
      logic [15:0] araw;
      logic [63:0] nsteps;
      logic [31:0] diff;
      logic [15:0] np;
      logic [31:0] d;
      r = '{ST_OK, 2'b00, 2'b00, 1'b0, 9'd0};
      sel_ok = (c.idx == 2'd1) || (c.idx == 2'd2);
      m = sel_ok ? int'(c.idx) - 1 : 0;
      araw = c.angle;
      if (c.kind == KIND_TICK) begin
         // finished runs stop first, then each live motor steps once its interval is up
         for (int k = 0; k < 2; k++) begin
            if (!run_on[k]) continue;
            if (timed_run[k]) begin
               diff = c.now_ms - stop_ms[k];
               if (!diff[31]) begin
                  halt_motor(k);
                  continue;
               end
            end else if (steps_togo[k] == 0) begin
               halt_motor(k);
               continue;
            end
            diff = c.now_us - last_pulse_us[k];
            if (diff < {16'd0, cfg_interval}) continue;
            last_pulse_us[k] = c.now_us;
            np = rev_pos[k] + 16'd1;
            if (cfg_spr != 0 && np >= cfg_spr) np = '0;
            rev_pos[k] = np;
            r.step_mask[k] = 1'b1;
            if (!timed_run[k]) begin
               steps_togo[k] = steps_togo[k] - 24'd1;
               if (steps_togo[k] == 0) halt_motor(k);
            end
         end
      end else if (!sel_ok) begin
         r.status = ST_BAD_MOTOR;
      end else if (c.kind == KIND_QUERY) begin
         r.status = ST_OK;
      end else if (run_on[m]) begin
         r.status = ST_BUSY;
      end else if (c.kind == KIND_TIMED) begin
         if (c.dur == 0) begin
            r.status = ST_BAD_DURATION;
         end else begin
            timed_run[m]     = 1'b1;
            run_on[m]        = 1'b1;
            stop_ms[m]       = c.now_ms + {1'b0, c.dur};
            last_pulse_us[m] = '0;
            steps_togo[m]    = '0;
         end
      end else begin
         // rounded steps = (spr * angle + 180) / 360
         nsteps = 64'(cfg_spr);
         nsteps = (nsteps * 64'(araw) + 64'd180) / 64'd360;
         if (araw[15] || araw == 0 || nsteps == 0) begin
            r.status = ST_BAD_ANGLE;
         end else begin
            timed_run[m]     = 1'b0;
            run_on[m]        = 1'b1;
            stop_ms[m]       = '0;
            last_pulse_us[m] = '0;
            steps_togo[m]    = nsteps[23:0];
         end
      end
      for (int k = 0; k < 2; k++) r.enable_mask[k] = run_on[k];
      if (sel_ok) begin
         r.running = run_on[m];
         if (cfg_spr != 0) begin
            d = 32'(rev_pos[m] % cfg_spr);
            d = (d * 32'd360) / 32'(cfg_spr);
            r.position_deg = d[8:0];
         end
      end
      return r;
   endfunction

   // Offers one beat, holds it until accepted, then books the reply it owes.
   task automatic issue(input motor_cmd_type c, input logic fixed, input motor_rsp_type want);
      motor_rsp_type got;
      req_valid       <= 1'b1;
      req_kind        <= c.kind;
      req_motor_index <= c.idx;
      req_duration_ms <= c.dur;
      req_angle_deg   <= c.angle;
      req_now_ms      <= c.now_ms;
      req_now_us      <= c.now_us;
      do @(posedge clock); while (req_stall);
      got = apply_command(c);
      replies_due.push_back(fixed ? want : got);
   endtask

   // Both registers in back-to-back beats; valid stays up across the pair.
   task automatic set_config(input logic [15:0] interval, input logic [15:0] spr);
      csr_valid <= 1'b1;
      csr_index <= CSR_STEP_INTERVAL;
      csr_wdata <= interval;
      do @(posedge clock); while (!csr_ready);
      cfg_interval = interval;
      csr_index <= CSR_STEPS_PER_REV;
      csr_wdata <= spr;
      do @(posedge clock); while (!csr_ready);
      cfg_spr = spr;
      csr_valid <= 1'b0;
   endtask

   task automatic drain_replies();
      while (replies_due.size() != 0) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard ceiling on the run; a correct run finishes well inside it.
   initial begin
      #4_000_000;
      $display("dual_stepper_pulse_controller_core test failed");
      $finish;
   end

   // Reply side: check every accepted beat against the oldest booked reply, then pick
   // the stall for the next cycle (long hold-off wins over the random pattern).
   initial begin
      motor_rsp_type want;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (replies_due.size() == 0) begin
               $error("reply beat with nothing owed: status %0d", rsp_status);
               fail_count++;
            end else begin
               want = replies_due.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_step_mask !== want.step_mask) begin
                  $error("step_mask: expected %0d, got %0d", want.step_mask, rsp_step_mask);
                  fail_count++;
               end
               if (rsp_enable_mask !== want.enable_mask) begin
                  $error("enable_mask: expected %0d, got %0d", want.enable_mask,
                         rsp_enable_mask);
                  fail_count++;
               end
               if (rsp_running !== want.running) begin
                  $error("running: expected %0d, got %0d", want.running, rsp_running);
                  fail_count++;
               end
               if (rsp_position_deg !== want.position_deg) begin
                  $error("position_deg: expected %0d, got %0d", want.position_deg,
                         rsp_position_deg);
                  fail_count++;
               end
            end
         end
         if (rx_hold > 0) begin
            rsp_stall <= 1'b1;
            rx_hold = rx_hold - 1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rx_stall_pct);
         end
      end
   end

   // Request side and phase sequencing.
   initial begin
      dir_row_type   rows [NUM_ROWS];
      int            ph_interval [NUM_PHASES];
      int            ph_spr [NUM_PHASES];
      motor_cmd_type c;
      motor_rsp_type none;
      int            pick;
      int            max_ang;

      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_kind        <= KIND_TICK;
      req_motor_index <= '0;
      req_duration_ms <= '0;
      req_angle_deg   <= '0;
      req_now_ms      <= '0;
      req_now_us      <= '0;
      csr_valid       <= 1'b0;
      csr_index       <= CSR_STEP_INTERVAL;
      csr_wdata       <= '0;
      fail_count   = 0;
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      rx_hold      = 0;
      none = '{ST_OK, 2'b00, 2'b00, 1'b0, 9'd0};

      // mirror starts at the reset values of the block
      cfg_interval = RESET_STEP_INTERVAL;
      cfg_spr      = RESET_STEPS_PER_REV;
      for (int k = 0; k < 2; k++) begin
         halt_motor(k);
         stop_ms[k]       = '0;
         last_pulse_us[k] = '0;
         rev_pos[k]       = '0;
      end

      // Directed rows. Replies of the first rows (fresh reset, every refusal code, busy)
      // are typed in; the rest run a short angle run, a timed run ending at the wrap
      // point and the time extremes through the predictor.
      rows[0]  = '{'{KIND_QUERY, 2'd1, 31'd0, 16'sd0, 32'd0, 32'd0}, 1'b1, none};
      rows[1]  = '{'{KIND_QUERY, 2'd0, 31'd0, 16'sd0, 32'd0, 32'd0}, 1'b1,
                   '{ST_BAD_MOTOR, 2'b00, 2'b00, 1'b0, 9'd0}};
      rows[2]  = '{'{KIND_QUERY, 2'd3, 31'd0, 16'sd0, 32'd0, 32'd0}, 1'b1,
                   '{ST_BAD_MOTOR, 2'b00, 2'b00, 1'b0, 9'd0}};
      rows[3]  = '{'{KIND_TICK, 2'd0, 31'd0, 16'sd0, 32'd0, 32'd0}, 1'b1, none};
      rows[4]  = '{'{KIND_TIMED, 2'd1, 31'd0, 16'sd0, 32'd0, 32'd0}, 1'b1,
                   '{ST_BAD_DURATION, 2'b00, 2'b00, 1'b0, 9'd0}};
      rows[5]  = '{'{KIND_ANGLE, 2'd2, 31'd0, 16'sd0, 32'd0, 32'd0}, 1'b1,
                   '{ST_BAD_ANGLE, 2'b00, 2'b00, 1'b0, 9'd0}};
      rows[6]  = '{'{KIND_ANGLE, 2'd2, 31'd0, 16'sh8000, 32'd0, 32'd0}, 1'b1,
                   '{ST_BAD_ANGLE, 2'b00, 2'b00, 1'b0, 9'd0}};
      rows[7]  = '{'{KIND_ANGLE, 2'd2, 31'd0, 16'shFFFF, 32'd0, 32'd0}, 1'b1,
                   '{ST_BAD_ANGLE, 2'b00, 2'b00, 1'b0, 9'd0}};
      rows[8]  = '{'{KIND_ANGLE, 2'd0, 31'd0, 16'sd90, 32'd0, 32'd0}, 1'b1,
                   '{ST_BAD_MOTOR, 2'b00, 2'b00, 1'b0, 9'd0}};
      rows[9]  = '{'{KIND_TIMED, 2'd3, 31'd5, 16'sd0, 32'd0, 32'd0}, 1'b1,
                   '{ST_BAD_MOTOR, 2'b00, 2'b00, 1'b0, 9'd0}};
      rows[10] = '{'{KIND_ANGLE, 2'd1, 31'd0, 16'sd1, 32'd0, 32'd0}, 1'b0, none};
      rows[11] = '{'{KIND_ANGLE, 2'd1, 31'd0, 16'sd5, 32'd0, 32'd0}, 1'b1,
                   '{ST_BUSY, 2'b00, 2'b01, 1'b1, 9'd0}};
      rows[12] = '{'{KIND_TIMED, 2'd2, 31'h7FFFFFFF, 16'sd0, 32'hFFFFFFFF, 32'd0}, 1'b0, none};
      rows[13] = '{'{KIND_TICK, 2'd1, 31'd0, 16'sd0, 32'd0, 32'd1199}, 1'b0, none};
      rows[14] = '{'{KIND_TICK, 2'd2, 31'd0, 16'sd0, 32'd0, 32'd1200}, 1'b0, none};
      rows[15] = '{'{KIND_QUERY, 2'd1, 31'd0, 16'sd0, 32'd0, 32'd0}, 1'b0, none};
      rows[16] = '{'{KIND_TICK, 2'd1, 31'd0, 16'sd0, 32'h7FFFFFFE, 32'd2400}, 1'b0, none};
      rows[17] = '{'{KIND_ANGLE, 2'd1, 31'd0, 16'sd32767, 32'd0, 32'd0}, 1'b0, none};
      rows[18] = '{'{KIND_TIMED, 2'd1, 31'd100, 16'sd0, 32'd0, 32'd0}, 1'b0, none};
      rows[19] = '{'{KIND_TICK, 2'd1, 31'd0, 16'sd0, 32'd0, 32'hFFFFFFFF}, 1'b0, none};
      rows[20] = '{'{KIND_QUERY, 2'd2, 31'd0, 16'sd0, 32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b0, none};
      rows[21] = '{'{KIND_TICK, 2'd3, 31'd0, 16'sd0, 32'd0, 32'd0}, 1'b0, none};
      rows[22] = '{'{KIND_ANGLE, 2'd2, 31'd0, 16'sd359, 32'd0, 32'd0}, 1'b0, none};

      // register settings per random phase; zero interval, zero steps per rev and a drop of
      // steps per rev below the current position (phase 5 after phase 4) are in here
      ph_interval = '{1200, 1, 65535, 0, 37, 37, 500, 2};
      ph_spr      = '{200, 1, 65535, 0, 400, 7, 360, 13};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_ROWS; i++) issue(rows[i].cmd, rows[i].fixed, rows[i].want);
      req_valid <= 1'b0;

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         drain_replies();
         set_config(16'(ph_interval[ph]), 16'(ph_spr[ph]));
         // idling pattern cycles through: none, sender, receiver, both
         case (ph % 4)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 63; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 63; end
            default: begin tx_idle_pct = 34; rx_stall_pct = 34; end
         endcase
         // long receiver hold-off while beats keep coming: queue fills, req_stall rises
         if (ph == 2) rx_hold = 600;
         t_ms = $urandom;
         t_us = $urandom;
         max_ang = (cfg_spr >= 16'd1000) ? 2 : 400;
         repeat (PHASE_BEATS) begin
            if ($urandom_range(0, 99) < tx_idle_pct) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 50)) @(posedge clock);
            end
            c = '{KIND_TICK, 2'd1, 31'd0, 16'sd0, 32'd0, 32'd0};
            c.idx = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3))
                                                : 2'($urandom_range(1, 2));
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               // well-formed tick: time moves on around the step interval
               c.kind = KIND_TICK;
               t_us = t_us + $urandom_range(0, 2 * int'(cfg_interval) + 2);
               t_ms = t_ms + $urandom_range(0, 6);
            end else if (pick < 57) begin
               c.kind = KIND_TIMED;
               c.dur  = ($urandom_range(0, 9) == 0) ? 31'd0 : 31'($urandom_range(1, 60));
            end else if (pick < 69) begin
               c.kind = KIND_ANGLE;
               case ($urandom_range(0, 19))
                  0:       c.angle = -16'sd1 * 16'($urandom_range(0, 32768));
                  1:       c.angle = 16'($urandom_range(1, 32767));
                  default: c.angle = 16'($urandom_range(1, max_ang));
               endcase
            end else if (pick < 80) begin
               c.kind = KIND_QUERY;
            end else begin
               // noise: every field fully random, time base jumps with it
               c.kind  = kind_type'($urandom_range(0, 3));
               c.idx   = 2'($urandom_range(0, 3));
               c.dur   = 31'($urandom);
               c.angle = 16'($urandom);
               t_ms    = $urandom;
               t_us    = $urandom;
            end
            c.now_ms = t_ms;
            c.now_us = t_us;
            issue(c, 1'b0, none);
         end
         req_valid <= 1'b0;
      end

      drain_replies();
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("dual_stepper_pulse_controller_core test passed");
      else
         $display("dual_stepper_pulse_controller_core test failed");
      $finish;
   end

endmodule
